// ===== hw/rtl/lcs_pkg.sv =====
`timescale 1ns / 1ps

package lcs_pkg;

    // Fixed field widths of the channels
    localparam int NODE_W = 11;
    localparam int SIZE_W = 11;

    localparam logic [NODE_W-1:0] NODE_COUNT_RST = 11'd1024;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_A,
        ST_FIND_B,
        ST_LINK,
        ST_GROW,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;    // take an edge word this cycle if offered
        logic read_a;      // start root search at endpoint a
        logic read_b;      // start root search at endpoint b
        logic follow;      // step to the parent link just read
        logic root_a;      // capture root of a
        logic root_b;      // capture root of b
        logic link_small;  // hang smaller root under larger
        logic grow_big;    // write merged size at larger root
        logic load_out;    // load result register
        logic clr_start;   // restart clear sweep, reset best and flag
        logic clr_step;    // write one cleared entry
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic edge_ok;     // edge word names a usable, non-self edge
        logic in_last;
        logic is_root;     // entry just read links to itself
        logic same_root;   // current root equals root of a
        logic last_held;   // accepted word was the last of its graph
        logic out_free;
        logic clr_last;
    } sts_t;

endpackage

// ===== hw/rtl/lcs_edge_if.sv =====
`timescale 1ns / 1ps

interface lcs_edge_if;
    logic                        valid;
    logic                        ready;
    logic                        has_edge;
    logic [lcs_pkg::NODE_W-1:0]  node_a;
    logic [lcs_pkg::NODE_W-1:0]  node_b;
    logic                        last_edge;

    modport source (output valid, has_edge, node_a, node_b, last_edge, input ready);
    modport sink   (input valid, has_edge, node_a, node_b, last_edge, output ready);
endinterface

// ===== hw/rtl/lcs_result_if.sv =====
`timescale 1ns / 1ps

interface lcs_result_if;
    logic                        valid;
    logic                        ready;
    logic [lcs_pkg::SIZE_W-1:0]  largest_component;
    logic                        bad_edge_seen;

    modport source (output valid, largest_component, bad_edge_seen, input ready);
    modport sink   (input valid, largest_component, bad_edge_seen, output ready);
endinterface

// ===== hw/rtl/lcs_cfg_if.sv =====
`timescale 1ns / 1ps

interface lcs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lcs_pkg::NODE_W-1:0]  node_count;

    modport source (output valid, node_count, input ready);
    modport sink   (input valid, node_count, output ready);
endinterface

// ===== hw/rtl/lcs_ram.sv =====
`timescale 1ns / 1ps

module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lcs_ctrl.sv =====
`timescale 1ns / 1ps

module lcs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  lcs_pkg::sts_t sts,
    output lcs_pkg::cmd_t cmd
);

    lcs_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcs_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            lcs_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = lcs_pkg::ST_IDLE;
                end
            end
            lcs_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    if (sts.edge_ok)
                    begin
                        cmd.read_a = 1'b1;
                        state_next = lcs_pkg::ST_FIND_A;
                    end
                    else if (sts.in_last)
                    begin
                        state_next = lcs_pkg::ST_EMIT;
                    end
                end
            end
            lcs_pkg::ST_FIND_A:
            begin
                if (sts.is_root)
                begin
                    cmd.root_a = 1'b1;
                    cmd.read_b = 1'b1;
                    state_next = lcs_pkg::ST_FIND_B;
                end
                else
                begin
                    cmd.follow = 1'b1;
                end
            end
            lcs_pkg::ST_FIND_B:
            begin
                if (sts.is_root)
                begin
                    cmd.root_b = 1'b1;
                    if (!sts.same_root)
                    begin
                        state_next = lcs_pkg::ST_LINK;
                    end
                    else if (sts.last_held)
                    begin
                        state_next = lcs_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = lcs_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.follow = 1'b1;
                end
            end
            lcs_pkg::ST_LINK:
            begin
                cmd.link_small = 1'b1;
                state_next     = lcs_pkg::ST_GROW;
            end
            lcs_pkg::ST_GROW:
            begin
                cmd.grow_big = 1'b1;
                state_next   = sts.last_held ? lcs_pkg::ST_EMIT : lcs_pkg::ST_IDLE;
            end
            lcs_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.clr_start = 1'b1;
                    state_next    = lcs_pkg::ST_CLEAR;
                end
            end
            default:
            begin
                state_next = lcs_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lcs_datapath.sv =====
`timescale 1ns / 1ps

module lcs_datapath #(
    parameter int MAX_NODES = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    lcs_edge_if.sink      edge_in,
    lcs_result_if.source  result_out,
    lcs_cfg_if.sink       cfg,
    input  lcs_pkg::cmd_t cmd,
    output lcs_pkg::sts_t sts
);

    localparam int          IW   = $clog2(MAX_NODES);
    localparam int          SW   = $clog2(MAX_NODES + 1);
    localparam int          EW   = IW + SW;
    localparam logic [31:0] MaxN = 32'(MAX_NODES);

    // configuration
    logic [lcs_pkg::NODE_W-1:0] node_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= lcs_pkg::NODE_COUNT_RST;
        end
        else if (cfg.valid)
        begin
            node_count_reg <= cfg.node_count;
        end
    end

    assign cfg.ready = 1'b1;

    // endpoint checks on the offered word
    logic          a_ok, b_ok, in_range, accept;
    logic [31:0]   a_m1, b_m1;
    logic [IW-1:0] idx_a, idx_b;

    assign a_ok = (edge_in.node_a != '0) && (edge_in.node_a <= node_count_reg)
                  && (32'(edge_in.node_a) <= MaxN);
    assign b_ok = (edge_in.node_b != '0) && (edge_in.node_b <= node_count_reg)
                  && (32'(edge_in.node_b) <= MaxN);
    assign in_range = a_ok && b_ok;
    assign a_m1     = 32'(edge_in.node_a) - 32'd1;
    assign b_m1     = 32'(edge_in.node_b) - 32'd1;
    assign idx_a    = a_m1[IW-1:0];
    assign idx_b    = b_m1[IW-1:0];

    assign edge_in.ready = cmd.in_ready;
    assign accept        = edge_in.valid && cmd.in_ready;

    // store: {parent link, component size} per node
    logic          we;
    logic [IW-1:0] waddr;
    logic [EW-1:0] wdata, rdata;
    logic [IW-1:0] rd_link;
    logic [SW-1:0] rd_size;

    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] b_idx_reg, ra_reg, rb_reg, clr_cnt_reg;
    logic [SW-1:0] sa_reg, sb_reg, best_reg;
    logic          last_reg, bad_reg;

    assign rd_link = rdata[EW-1:SW];
    assign rd_size = rdata[SW-1:0];

    always_comb
    begin
        if (cmd.read_a)
        begin
            cur_next = idx_a;
        end
        else if (cmd.read_b)
        begin
            cur_next = b_idx_reg;
        end
        else if (cmd.follow)
        begin
            cur_next = rd_link;
        end
        else
        begin
            cur_next = cur_reg;
        end
    end

    lcs_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_NODES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (cur_next),
        .rdata (rdata)
    );

    // union by size
    logic          swap;
    logic [IW-1:0] big, small_root;
    logic [SW-1:0] small_size, merged;

    assign swap       = sa_reg < sb_reg;
    assign big        = swap ? rb_reg : ra_reg;
    assign small_root = swap ? ra_reg : rb_reg;
    assign small_size = swap ? sa_reg : sb_reg;
    assign merged     = sa_reg + sb_reg;

    always_comb
    begin
        we    = cmd.clr_step || cmd.link_small || cmd.grow_big;
        waddr = clr_cnt_reg;
        wdata = {clr_cnt_reg, SW'(1)};
        if (cmd.link_small)
        begin
            waddr = small_root;
            wdata = {big, small_size};
        end
        else if (cmd.grow_big)
        begin
            waddr = big;
            wdata = {big, merged};
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (accept)
        begin
            b_idx_reg <= idx_b;
        end
        if (cmd.root_a)
        begin
            ra_reg <= cur_reg;
            sa_reg <= rd_size;
        end
        if (cmd.root_b)
        begin
            rb_reg <= cur_reg;
            sb_reg <= rd_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg    <= 1'b0;
            bad_reg     <= 1'b0;
            best_reg    <= SW'(1);
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                last_reg <= edge_in.last_edge;
            end
            if (cmd.clr_start)
            begin
                bad_reg     <= 1'b0;
                best_reg    <= SW'(1);
                clr_cnt_reg <= '0;
            end
            else
            begin
                if (accept && edge_in.has_edge && !in_range)
                begin
                    bad_reg <= 1'b1;
                end
                if (cmd.grow_big && (merged > best_reg))
                begin
                    best_reg <= merged;
                end
                if (cmd.clr_step)
                begin
                    clr_cnt_reg <= clr_cnt_reg + IW'(1);
                end
            end
        end
    end

    // result register
    logic                       out_valid_reg;
    logic [lcs_pkg::SIZE_W-1:0] out_size_reg;
    logic                       out_bad_reg;
    logic [31:0]                best_wide;

    assign best_wide = 32'(best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_size_reg <= best_wide[lcs_pkg::SIZE_W-1:0];
            out_bad_reg  <= bad_reg;
        end
    end

    assign result_out.valid             = out_valid_reg;
    assign result_out.largest_component = out_size_reg;
    assign result_out.bad_edge_seen     = out_bad_reg;

    // status
    assign sts.in_valid  = edge_in.valid;
    assign sts.edge_ok   = edge_in.has_edge && in_range && (edge_in.node_a != edge_in.node_b);
    assign sts.in_last   = edge_in.last_edge;
    assign sts.is_root   = rd_link == cur_reg;
    assign sts.same_root = cur_reg == ra_reg;
    assign sts.last_held = last_reg;
    assign sts.out_free  = !out_valid_reg || result_out.ready;
    assign sts.clr_last  = clr_cnt_reg == IW'(MAX_NODES - 1);

endmodule

// ===== hw/rtl/largest_component_size_core.sv =====
`timescale 1ns / 1ps

// Channel      Dir  Payload                               Handshake
// edge_in      in   has_edge, node_a, node_b, last_edge   valid/ready
// result_out   out  largest_component, bad_edge_seen      valid/ready
// cfg          in   node_count                            valid/ready (ready always high)
//
// An edge word is accepted, then each endpoint is followed up its parent links
// to its root (depth stays at or below log2 of MAX_NODES under union by size),
// then two writes, link and grow, are made when two components merge. A
// rejected, self-loop or empty word is accepted and needs no further step.
// Reset and every result start a clear sweep over all MAX_NODES entries, one
// entry per cycle, during which no edge word is taken.
// A result waits in its output register; the sweep starts once it is loaded.

module largest_component_size_core #(
    parameter int MAX_NODES = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    lcs_edge_if.sink     edge_in,
    lcs_result_if.source result_out,
    lcs_cfg_if.sink      cfg
);

    // command and status between the sequencer and the union-find datapath
    lcs_pkg::cmd_t cmd;
    lcs_pkg::sts_t sts;

    // sequencer: clear sweep, accept, two root walks, merge, emit
    lcs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // datapath: node store, root/size registers, running maximum, sticky flag
    lcs_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_in    (edge_in),
        .result_out (result_out),
        .cfg        (cfg),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Edge words go in one graph at a time; a result word comes back for each
// word flagged last_edge. The bench keeps its own union-find forest in step
// with every accepted edge word, so the expected result is known the moment
// the last word of a graph is taken.
module tb;

    localparam int MAX_NODES    = 1024;
    localparam int LINK_W       = $clog2(MAX_NODES);
    localparam int SETTLE_WAIT  = 64;    // covers two deepest root walks plus a merge
    localparam int DRAIN_WAIT   = 200;
    localparam int QUIET_LIMIT  = 8000;  // clear sweep + longest stalls, several times over
    localparam int RANDOM_EDGES = 1250;

    typedef struct packed {
        logic [lcs_pkg::SIZE_W-1:0] largest;
        logic                       bad_seen;
    } graph_result_t;

    typedef enum logic {
        ROW_WORD,
        ROW_COUNT
    } row_kind_t;

    // One line of the directed table. A ROW_COUNT line carries the new
    // node count in node_a. want is used only when checked is set.
    typedef struct {
        row_kind_t                  kind;
        logic                       has_edge;
        logic [lcs_pkg::NODE_W-1:0] node_a;
        logic [lcs_pkg::NODE_W-1:0] node_b;
        logic                       last_edge;
        logic                       checked;
        graph_result_t              want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    lcs_edge_if   edge_bus ();
    lcs_result_if result_bus ();
    lcs_cfg_if    cfg_bus ();

    largest_component_size_core #(
        .MAX_NODES (MAX_NODES)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_in    (edge_bus),
        .result_out (result_bus),
        .cfg        (cfg_bus)
    );

    // ------------------------------------------------------------------
    // Bench-side forest: parent links, sizes at the roots, running peak
    // ------------------------------------------------------------------
    logic [LINK_W-1:0]          up_link   [MAX_NODES];
    logic [lcs_pkg::SIZE_W-1:0] comp_size [MAX_NODES];
    logic [lcs_pkg::SIZE_W-1:0] peak_size;
    logic                       stray_flag;
    logic [lcs_pkg::NODE_W-1:0] node_limit;

    graph_result_t component_q [$];   // results owed by the block, oldest first
    plan_row_t     plan [$];
    int            mismatch_cnt;
    int            quiet_cycles;
    logic          calm;              // phase with no idling on either side

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_forest();
        for (int i = 0; i < MAX_NODES; i++)
        begin
            up_link[i]   = LINK_W'(i);
            comp_size[i] = lcs_pkg::SIZE_W'(1);
        end
        peak_size  = lcs_pkg::SIZE_W'(1);
        stray_flag = 1'b0;
    endfunction

    // path halving; does not change which node ends up as root
    function automatic logic [LINK_W-1:0] root_of(input logic [LINK_W-1:0] x);
        logic [LINK_W-1:0] n;
        n = x;
        while (up_link[n] != n)
        begin
            up_link[n] = up_link[up_link[n]];
            n = up_link[n];
        end
        return n;
    endfunction

    function automatic void join_nodes(input logic [lcs_pkg::NODE_W-1:0] a,
                                       input logic [lcs_pkg::NODE_W-1:0] b);
        int                         lim;
        logic [LINK_W-1:0]          ra;
        logic [LINK_W-1:0]          rb;
        logic [LINK_W-1:0]          swap;
        logic [lcs_pkg::SIZE_W-1:0] merged;
        // counts above the store size act as the store size; zero rejects all
        lim = (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
        if (a == 0 || b == 0 || a > lim || b > lim)
        begin
            stray_flag = 1'b1;
            return;
        end
        if (a == b)
            return;
        ra = root_of(LINK_W'(a - lcs_pkg::NODE_W'(1)));
        rb = root_of(LINK_W'(b - lcs_pkg::NODE_W'(1)));
        if (ra == rb)
            return;
        // smaller tree goes under the larger; ties keep a's root on top
        if (comp_size[ra] < comp_size[rb])
        begin
            swap = ra;
            ra   = rb;
            rb   = swap;
        end
        merged        = comp_size[ra] + comp_size[rb];
        up_link[rb]   = ra;
        comp_size[ra] = merged;
        if (merged > peak_size)
            peak_size = merged;
    endfunction

    // Apply one accepted edge word; a last word yields the graph's result
    // and returns the forest to its cleared state.
    function automatic void fold_word(input logic has_edge,
                                      input logic [lcs_pkg::NODE_W-1:0] a,
                                      input logic [lcs_pkg::NODE_W-1:0] b,
                                      input logic last_edge,
                                      output logic emits, output graph_result_t res);
        if (has_edge)
            join_nodes(a, b);
        emits        = last_edge;
        res.largest  = peak_size;
        res.bad_seen = stray_flag;
        if (last_edge)
            clear_forest();
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    function automatic void plan_word(input logic has_edge, input int a, input int b,
                                      input logic last_edge);
        plan_row_t row;
        row.kind      = ROW_WORD;
        row.has_edge  = has_edge;
        row.node_a    = lcs_pkg::NODE_W'(a);
        row.node_b    = lcs_pkg::NODE_W'(b);
        row.last_edge = last_edge;
        row.checked   = 1'b0;
        row.want      = '0;
        plan.insert(plan.size(), row);
    endfunction

    // last word of a graph whose answer is obvious; typed in by hand
    function automatic void plan_known(input logic has_edge, input int a, input int b,
                                       input int want_size, input logic want_bad);
        plan_row_t row;
        row.kind          = ROW_WORD;
        row.has_edge      = has_edge;
        row.node_a        = lcs_pkg::NODE_W'(a);
        row.node_b        = lcs_pkg::NODE_W'(b);
        row.last_edge     = 1'b1;
        row.checked       = 1'b1;
        row.want.largest  = lcs_pkg::SIZE_W'(want_size);
        row.want.bad_seen = want_bad;
        plan.insert(plan.size(), row);
    endfunction

    function automatic void plan_count(input int value);
        plan_row_t row;
        row.kind      = ROW_COUNT;
        row.has_edge  = 1'b0;
        row.node_a    = lcs_pkg::NODE_W'(value);
        row.node_b    = '0;
        row.last_edge = 1'b0;
        row.checked   = 1'b0;
        row.want      = '0;
        plan.insert(plan.size(), row);
    endfunction

    // ------------------------------------------------------------------
    // Edge word driver. valid stays high across back-to-back words so it
    // never gets two assignments in one step.
    // ------------------------------------------------------------------
    task automatic send_word(input logic has_edge, input logic [lcs_pkg::NODE_W-1:0] a,
                             input logic [lcs_pkg::NODE_W-1:0] b, input logic last_edge,
                             input logic checked, input graph_result_t want);
        int            gap;
        logic          emits;
        graph_result_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            edge_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        edge_bus.valid     <= 1'b1;
        edge_bus.has_edge  <= has_edge;
        edge_bus.node_a    <= a;
        edge_bus.node_b    <= b;
        edge_bus.last_edge <= last_edge;
        do @(posedge clk); while (!edge_bus.ready);
        fold_word(has_edge, a, b, last_edge, emits, res);
        if (emits)
            component_q.insert(component_q.size(), checked ? want : res);
    endtask

    // Count writes only with the block idle. A graph may still be open, so
    // after the last owed result the block gets time to finish any edge word.
    task automatic set_node_count(input logic [lcs_pkg::NODE_W-1:0] value);
        edge_bus.valid <= 1'b0;
        while (component_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.node_count <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        node_limit = value;
    endtask

    // One random graph: mostly in-range edges over the current count, with
    // self-loops, out-of-range endpoints and empty words mixed in.
    task automatic random_graph(inout int edge_words);
        int                         len;
        int                         eff;
        int                         r;
        logic                       has_edge;
        logic [lcs_pkg::NODE_W-1:0] a;
        logic [lcs_pkg::NODE_W-1:0] b;
        logic [lcs_pkg::NODE_W-1:0] stray;
        eff = (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
        for (int i = 0; i < len; i++)
        begin
            r        = $urandom_range(0, 99);
            has_edge = 1'b1;
            if (eff > 0)
            begin
                a = lcs_pkg::NODE_W'($urandom_range(1, eff));
                b = lcs_pkg::NODE_W'($urandom_range(1, eff));
            end
            else
            begin
                a = lcs_pkg::NODE_W'($urandom_range(0, 2047));
                b = lcs_pkg::NODE_W'($urandom_range(0, 2047));
            end
            stray = ($urandom_range(0, 2) == 0) ? '0
                    : lcs_pkg::NODE_W'($urandom_range(eff + 1, 2047));
            if (r < 4)
            begin
                // empty word; a one-word graph of this kind is an empty graph
                has_edge = 1'b0;
                a = lcs_pkg::NODE_W'($urandom_range(0, 2047));
                b = lcs_pkg::NODE_W'($urandom_range(0, 2047));
            end
            else if (r < 9)
                b = a;
            else if (r < 14)
            begin
                if ($urandom_range(0, 1) == 1)
                    a = stray;
                else
                    b = stray;
            end
            send_word(has_edge, a, b, (i == len - 1), 1'b0, '0);
            if (has_edge)
                edge_words++;
        end
    endtask

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(2, 24);
        if (r < 70)
            return $urandom_range(25, 200);
        if (r < 80)
            return MAX_NODES;
        if (r < 85)
            return $urandom_range(MAX_NODES + 1, 2047);
        if (r < 88)
            return 0;
        if (r < 91)
            return 1;
        return $urandom_range(0, 2047);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ------------------------------------------------------------------
    initial
    begin : result_pacer
        int run;
        int stall;
        result_bus.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            result_bus.ready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    task automatic flag_result(input string what, input graph_result_t want,
                               input graph_result_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t %s: want size %0d bad %0b, got size %0d bad %0b", $time, what,
                     want.largest, want.bad_seen, got.largest, got.bad_seen);
    endtask

    always @(posedge clk)
    begin : result_check
        graph_result_t got;
        graph_result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got.largest  = result_bus.largest_component;
            got.bad_seen = result_bus.bad_edge_seen;
            if (component_q.size() == 0)
                flag_result("result word with none owed", '0, got);
            else
            begin
                want = component_q.pop_front();
                if (got.largest !== want.largest || got.bad_seen !== want.bad_seen)
                    flag_result("result mismatch", want, got);
            end
        end
    end

    // Watchdog: any accepted word on any channel resets the quiet count.
    always @(posedge clk)
    begin
        if (!rst_n || (edge_bus.valid && edge_bus.ready)
                   || (result_bus.valid && result_bus.ready)
                   || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("largest_component_size_core test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int edge_words;
        int graphs;
        rst_n              = 1'b0;
        edge_bus.valid     = 1'b0;
        edge_bus.has_edge  = 1'b0;
        edge_bus.node_a    = '0;
        edge_bus.node_b    = '0;
        edge_bus.last_edge = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.node_count = '0;
        mismatch_cnt       = 0;
        quiet_cycles       = 0;
        calm               = 1'b0;
        edge_words         = 0;
        node_limit         = lcs_pkg::NODE_COUNT_RST;
        clear_forest();

        // Directed table. Count starts at its reset value of 1024.
        plan_known(1'b0, 2047, 2047, 1, 1'b0);       // empty graph right after reset
        plan_known(1'b1, 1, 1024, 2, 1'b0);          // both extreme nodes
        plan_known(1'b1, 0, 5, 1, 1'b1);             // node zero is out of range
        plan_word(1'b1, 1, 2, 1'b0);
        plan_word(1'b1, 2, 1, 1'b0);                 // already one component
        plan_word(1'b1, 3, 3, 1'b0);                 // self-loop
        plan_word(1'b1, 2, 3, 1'b1);
        plan_word(1'b1, 1, 2, 1'b0);
        plan_word(1'b1, 3, 4, 1'b0);
        plan_word(1'b1, 1, 3, 1'b0);                 // two equal trees
        plan_word(1'b1, 5, 5, 1'b0);
        plan_word(1'b0, 2047, 0, 1'b0);              // empty word inside a graph
        plan_word(1'b1, 4, 1025, 1'b0);              // just above the count
        plan_word(1'b1, 2, 4, 1'b1);
        plan_count(2047);                            // oversized count acts as 1024
        plan_known(1'b1, 1024, 1, 2, 1'b0);
        plan_known(1'b1, 1025, 1, 1, 1'b1);
        plan_count(0);                               // zero count rejects every edge
        plan_known(1'b1, 1, 2, 1, 1'b1);
        plan_count(1);
        plan_known(1'b1, 1, 1, 1, 1'b0);
        plan_known(1'b1, 1, 2, 1, 1'b1);
        plan_count(3);                               // raised to 3, then to 5 mid-graph
        plan_word(1'b1, 1, 2, 1'b0);
        plan_word(1'b1, 3, 4, 1'b0);
        plan_count(5);
        plan_word(1'b1, 3, 4, 1'b0);
        plan_word(1'b1, 4, 5, 1'b1);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_COUNT)
                set_node_count(plan[i].node_a);
            else
                send_word(plan[i].has_edge, plan[i].node_a, plan[i].node_b,
                          plan[i].last_edge, plan[i].checked, plan[i].want);
        end

        // Random phases: new count, a handful of graphs, idling on or off.
        while (edge_words < RANDOM_EDGES)
        begin
            set_node_count(lcs_pkg::NODE_W'(pick_count()));
            calm   = ($urandom_range(0, 4) == 0);
            graphs = $urandom_range(1, 5);
            for (int g = 0; g < graphs; g++)
                random_graph(edge_words);
        end

        edge_bus.valid <= 1'b0;
        while (component_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_cnt == 0 && component_q.size() == 0)
            $display("largest_component_size_core test passed");
        else
            $display("largest_component_size_core test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_edge_if.sv
hw/rtl/lcs_result_if.sv
hw/rtl/lcs_cfg_if.sv
hw/rtl/lcs_ram.sv
hw/rtl/lcs_ctrl.sv
hw/rtl/lcs_datapath.sv
hw/rtl/largest_component_size_core.sv
bench/tb.sv
